// ===== rtl/pvp_pkg.sv =====
package pvp_pkg;

  // Register reset values
  localparam logic [15:0] SUPPLY_RST = 16'd12000;
  localparam logic [15:0] PERIOD_RST = 16'd4000;

  // Configuration register indexes
  typedef enum logic {
    CFG_SUPPLY = 1'b0,
    CFG_PERIOD = 1'b1
  } cfg_idx_e;

  // Width of the magnitude square root (one root bit per stage)
  localparam int ROOT_W = 32;

  // Quarter-wave sine polynomial, Q30; highest order term first
  localparam logic [30:0] TAYLOR_C11 = 31'd3864;
  localparam logic [30:0] TAYLOR_COEF [5] = '{
    31'd172272, 31'd5026994, 31'd85569306, 31'd693598668, 31'd1686629713
  };
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  // sqrt(3)/2 in Q16
  localparam logic signed [16:0] HALF_SQRT3_Q16 = 17'sd56756;

endpackage

// ===== rtl/pvp_delay.sv =====
module pvp_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  // shift line, advances with the pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

// ===== rtl/pvp_sqrt.sv =====
module pvp_sqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [63:0]                rad_i,
  output logic [pvp_pkg::ROOT_W-1:0] root_o
);

  localparam int RW = pvp_pkg::ROOT_W;

  logic [RW+1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [63:0]   rad_q  [RW];

  // one root bit per stage, two radicand bits consumed per stage
  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic [RW+1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [63:0]   rad_in;
    logic [RW+3:0] work;
    logic [RW+3:0] trial;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign rad_in  = rad_q[j-1];
    end

    assign work  = {rem_in, rad_in[63:62]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = work >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? (RW+2)'(work - trial) : work[RW+1:0];
        root_q[j] <= {root_in[RW-2:0], ge};
        rad_q[j]  <= {rad_in[61:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

// ===== rtl/pvp_div.sv =====
module pvp_div #(
  parameter int DW = 16,
  parameter int QW = 17
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [QW+DW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  output logic [QW-1:0]    quo_o
);

  // restoring division, one quotient bit per stage;
  // the caller keeps num_i >> QW below den_i
  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   trial;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in = num_i[QW+DW-1:QW];
      assign den_in = den_i;
      assign low_in = num_i[QW-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign low_in = low_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        den_q[j] <= den_in;
        low_q[j] <= {low_in[QW-2:0], 1'b0};
        quo_q[j] <= {quo_in[QW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// ===== rtl/pvp_qsin.sv =====
module pvp_qsin (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [30:0]        x_i,
  input  logic               neg_i,
  output logic signed [16:0] sine_o
);

  // eight stages: square, five Horner steps, final product, round
  logic [61:0]        xx_q;
  logic [30:0]        x_q   [0:5];
  logic               neg_q [0:6];
  logic [30:0]        x2_q  [1:4];
  logic [61:0]        pr_q  [1:6];
  logic signed [16:0] sine_q;

  logic [30:0] t_c [2:6];
  logic [31:0] s_c;
  logic [31:0] sat_c;
  logic [16:0] rnd_c;

  // Horner coefficient minus previous product
  always_comb begin
    for (int i = 2; i <= 6; i++) begin
      t_c[i] = pvp_pkg::TAYLOR_COEF[i-2] - 31'(pr_q[i-1] >> 30);
    end
    s_c   = pr_q[6][61:30];
    sat_c = (s_c > pvp_pkg::ONE_Q30) ? pvp_pkg::ONE_Q30 : s_c;
    rnd_c = 17'((sat_c + 32'd16384) >> 15);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q     <= 62'(x_i) * 62'(x_i);
      x_q[0]   <= x_i;
      neg_q[0] <= neg_i;
      x2_q[1]  <= xx_q[60:30];
      pr_q[1]  <= 62'(xx_q[60:30]) * 62'(pvp_pkg::TAYLOR_C11);
      for (int i = 1; i <= 5; i++) begin
        x_q[i] <= x_q[i-1];
      end
      for (int i = 1; i <= 6; i++) begin
        neg_q[i] <= neg_q[i-1];
      end
      for (int i = 2; i <= 4; i++) begin
        x2_q[i] <= x2_q[i-1];
      end
      for (int i = 2; i <= 5; i++) begin
        pr_q[i] <= 62'(x2_q[i-1]) * 62'(t_c[i]);
      end
      pr_q[6] <= 62'(x_q[5]) * 62'(t_c[6]);
      sine_q  <= neg_q[6] ? -$signed(rnd_c) : $signed(rnd_c);
    end
  end

  assign sine_o = sine_q;

endmodule

// ===== rtl/phase_voltage_to_pwm_top.sv =====
// d/q voltage command plus electrical angle in, three PWM compare values out.
// Input channel: in_valid_i/in_ready_o carries volt_q_i, volt_d_i, elec_angle_i.
// Output channel: out_valid_o/out_ready_i carries compare_a_o..compare_c_o and
// was_limited_o. One result beat for every input beat, in order.
// Configuration: cfg_we_i writes cfg_data_i into supply (index 0) or period
// (index 1) at the clock edge; write only while no beat is in flight.
// Throughput: one beat per cycle while the output is not stalled. The
// pipeline depth is set by the 32-stage magnitude square root, the
// 33-stage limit divider and the 17-stage compare dividers, all pipelined.
// Stall: while an output beat waits for out_ready_i the whole pipeline holds
// and in_ready_o is low; nothing is dropped or repeated.
// Reset (rst_ni low, async): pipeline emptied, supply = 12000 mV,
// period = 4000.
module phase_voltage_to_pwm_top #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] volt_q_i,
  input  logic signed [15:0] volt_d_i,
  input  logic [15:0]        elec_angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        compare_a_o,
  output logic [15:0]        compare_b_o,
  output logic [15:0]        compare_c_o,
  output logic               was_limited_o
);

  // angle quantization constants
  localparam int KW = $clog2(SINE_TABLE_DEPTH);
  localparam int XW = 2 * KW;
  localparam int MW = XW + 2;
  localparam int SH = XW + KW;
  localparam longint unsigned TURN   = 64'd1 << 32;
  localparam longint unsigned STEP_Q = TURN / SINE_TABLE_DEPTH;
  localparam longint unsigned STEP_R = TURN % SINE_TABLE_DEPTH;
  localparam longint unsigned RECIP  = ((64'd1 << SH) / SINE_TABLE_DEPTH) + 64'd1;

  // pipeline timing
  localparam int RW       = pvp_pkg::ROOT_W;
  localparam int LDIV_QW  = 33;
  localparam int CDIV_QW  = 17;
  localparam int DIV_DONE = 2 + RW + LDIV_QW;
  localparam int SC_DONE  = 12;
  localparam int SC_DLY   = DIV_DONE + 1 - SC_DONE;
  localparam int CTL_DLY  = DIV_DONE - 2;
  localparam int CMP_IN   = DIV_DONE + 7;
  localparam int LAT      = CMP_IN + CDIV_QW + 1;

  logic            en;
  logic [LAT-1:0]  vld_q;
  logic [15:0]     supply_q;
  logic [15:0]     period_q;

  // global advance: the output register is free or being emptied
  assign en          = ~vld_q[LAT-1] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT-1];

  // control: valid bits and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      supply_q <= pvp_pkg::SUPPLY_RST;
      period_q <= pvp_pkg::PERIOD_RST;
    end else begin
      if (en) begin
        vld_q <= {vld_q[LAT-2:0], in_valid_i};
      end
      if (cfg_we_i) begin
        case (pvp_pkg::cfg_idx_e'(cfg_idx_i))
          pvp_pkg::CFG_SUPPLY: supply_q <= cfg_data_i;
          pvp_pkg::CFG_PERIOD: period_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // ---------------- stage 1: squares, products, table index
  logic signed [31:0] dsq_c, qsq_c;
  logic [15:0]        dabs_c, qabs_c;

  assign dsq_c  = volt_d_i * volt_d_i;
  assign qsq_c  = volt_q_i * volt_q_i;
  assign dabs_c = volt_d_i[15] ? 16'(-volt_d_i) : 16'(volt_d_i);
  assign qabs_c = volt_q_i[15] ? 16'(-volt_q_i) : 16'(volt_q_i);

  logic signed [15:0] d1_q, q1_q;
  logic [30:0]        dd1_q, qq1_q;
  logic [31:0]        ads1_q, aqs1_q, ss1_q;
  logic [KW-1:0]      k1_q;

  // ---------------- stage 2: 3*(d^2+q^2), limit test
  logic [31:0] m_c;
  logic [33:0] m3_c;

  assign m_c  = 32'(dd1_q) + 32'(qq1_q);
  assign m3_c = 34'(m_c) + {1'b0, m_c, 1'b0};

  logic [33:0]        m3_2_q;
  logic               lim2_q;
  logic [31:0]        ads2_q, aqs2_q;
  logic signed [15:0] d2_q, q2_q;
  logic [31:0]        kq2_q;
  logic [XW-1:0]      xr2_q;

  // angle to phase: k*2^32/depth by quotient part plus reciprocal remainder
  logic [31:0]      kq3_q;
  logic [XW+MW-1:0] pr3_q;
  logic [31:0]      p4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q   <= volt_d_i;
      q1_q   <= volt_q_i;
      dd1_q  <= dsq_c[30:0];
      qq1_q  <= qsq_c[30:0];
      ads1_q <= 32'(dabs_c) * 32'(supply_q);
      aqs1_q <= 32'(qabs_c) * 32'(supply_q);
      ss1_q  <= 32'(supply_q) * 32'(supply_q);
      k1_q   <= KW'((32'(elec_angle_i) * 32'(SINE_TABLE_DEPTH)) >> 16);

      m3_2_q <= m3_c;
      lim2_q <= m3_c > {2'b00, ss1_q};
      ads2_q <= ads1_q;
      aqs2_q <= aqs1_q;
      d2_q   <= d1_q;
      q2_q   <= q1_q;
      kq2_q  <= 32'(64'(k1_q) * STEP_Q);
      xr2_q  <= XW'(64'(k1_q) * STEP_R);

      kq3_q  <= kq2_q;
      pr3_q  <= (XW+MW)'(64'(xr2_q) * RECIP);

      p4_q   <= kq3_q + 32'(pr3_q >> SH);
    end
  end

  // ---------------- sine and cosine
  logic [31:0]        pc_c;
  logic [30:0]        xs_c, xc_c;
  logic signed [16:0] sn_c, cs_c;

  assign pc_c = p4_q + 32'h4000_0000;
  assign xs_c = p4_q[30] ? (31'h4000_0000 - {1'b0, p4_q[29:0]}) : {1'b0, p4_q[29:0]};
  assign xc_c = pc_c[30] ? (31'h4000_0000 - {1'b0, pc_c[29:0]}) : {1'b0, pc_c[29:0]};

  pvp_qsin u_sin (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (xs_c),
    .neg_i  (p4_q[31]),
    .sine_o (sn_c)
  );

  pvp_qsin u_cos (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (xc_c),
    .neg_i  (pc_c[31]),
    .sine_o (cs_c)
  );

  logic [33:0] sc_dly;

  pvp_delay #(.WIDTH(34), .DEPTH(SC_DLY)) u_dly_sc (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({sn_c, cs_c}),
    .q_o   (sc_dly)
  );

  // ---------------- magnitude limit: root then per-axis division
  logic [RW-1:0] root_c;
  logic [63:0]   prod_dly;
  logic [32:0]   ctl_dly;
  logic [32:0]   qd_c, qq_c;

  pvp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ({m3_2_q, 30'b0}),
    .root_o (root_c)
  );

  pvp_delay #(.WIDTH(64), .DEPTH(RW)) u_dly_prod (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({ads2_q, aqs2_q}),
    .q_o   (prod_dly)
  );

  pvp_delay #(.WIDTH(33), .DEPTH(CTL_DLY)) u_dly_ctl (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({lim2_q, d2_q, q2_q}),
    .q_o   (ctl_dly)
  );

  pvp_div #(.DW(RW), .QW(LDIV_QW)) u_div_d (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({2'b00, prod_dly[63:32], 31'b0}),
    .den_i (root_c),
    .quo_o (qd_c)
  );

  pvp_div #(.DW(RW), .QW(LDIV_QW)) u_div_q (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({2'b00, prod_dly[31:0], 31'b0}),
    .den_i (root_c),
    .quo_o (qq_c)
  );

  function automatic logic signed [34:0] limit_axis(logic lim, logic signed [15:0] v,
                                                    logic [32:0] qt);
    logic signed [34:0] mag;
    mag = $signed({2'b00, qt});
    if (lim) begin
      return v[15] ? -mag : mag;
    end
    return {{3{v[15]}}, v, 16'b0};
  endfunction

  // ---------------- inverse Park, inverse Clarke
  logic signed [34:0] vd68_q, vq68_q;
  logic               lim68_q;
  logic signed [16:0] sn68_c, cs68_c;

  assign sn68_c = $signed(sc_dly[33:17]);
  assign cs68_c = $signed(sc_dly[16:0]);

  logic signed [51:0] pa69_q, pb69_q, pc69_q, pd69_q;
  logic               lim69_q;
  logic signed [52:0] asum_c, bsum_c;

  assign asum_c = {pa69_q[51], pa69_q} - {pb69_q[51], pb69_q};
  assign bsum_c = {pc69_q[51], pc69_q} + {pd69_q[51], pd69_q};

  logic signed [39:0] alpha70_q, beta70_q, alpha71_q;
  logic               lim70_q, lim71_q;
  logic signed [56:0] bm71_q;
  logic signed [57:0] a15_c, bmx_c, ubs_c, ucs_c;

  assign a15_c = {{3{alpha71_q[39]}}, alpha71_q, 15'b0};
  assign bmx_c = {bm71_q[56], bm71_q};
  assign ubs_c = bmx_c - a15_c;
  assign ucs_c = 58'sd0 - a15_c - bmx_c;

  logic signed [39:0] u72_q [3];
  logic               lim72_q;

  // ---------------- duty to compare count
  logic signed [41:0] tv_c  [3];
  logic signed [58:0] nx73_q [3];
  logic               lim73_q;
  logic signed [41:0] nsh_c [3];
  logic [2:0]         ovf_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tv_c[i]  = $signed({u72_q[i][39], u72_q[i], 1'b0}) +
                 $signed({10'b0, supply_q, 16'b0});
      nsh_c[i] = 42'(nx73_q[i] >>> 17);
      ovf_c[i] = nsh_c[i][41:17] >= 25'(supply_q);
    end
  end

  logic [32:0] dvd74_q [3];
  logic [2:0]  neg74_q, ovf74_q;
  logic        lim74_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vd68_q  <= limit_axis(ctl_dly[32], $signed(ctl_dly[31:16]), qd_c);
      vq68_q  <= limit_axis(ctl_dly[32], $signed(ctl_dly[15:0]), qq_c);
      lim68_q <= ctl_dly[32];

      pa69_q  <= vd68_q * cs68_c;
      pb69_q  <= vq68_q * sn68_c;
      pc69_q  <= vd68_q * sn68_c;
      pd69_q  <= vq68_q * cs68_c;
      lim69_q <= lim68_q;

      alpha70_q <= 40'(asum_c >>> 15);
      beta70_q  <= 40'(bsum_c >>> 15);
      lim70_q   <= lim69_q;

      alpha71_q <= alpha70_q;
      bm71_q    <= beta70_q * pvp_pkg::HALF_SQRT3_Q16;
      lim71_q   <= lim70_q;

      u72_q[0] <= alpha71_q;
      u72_q[1] <= 40'(ubs_c >>> 16);
      u72_q[2] <= 40'(ucs_c >>> 16);
      lim72_q  <= lim71_q;

      for (int i = 0; i < 3; i++) begin
        nx73_q[i]  <= tv_c[i] * $signed({1'b0, period_q});
        neg74_q[i] <= nx73_q[i][58];
        ovf74_q[i] <= ovf_c[i];
        dvd74_q[i] <= (nx73_q[i][58] || ovf_c[i]) ? 33'd0 : nsh_c[i][32:0];
      end
      lim73_q <= lim72_q;
      lim74_q <= lim73_q;
    end
  end

  logic [16:0] cq_c [3];

  for (genvar g = 0; g < 3; g++) begin : g_cdiv
    pvp_div #(.DW(16), .QW(CDIV_QW)) u_div_cmp (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (dvd74_q[g]),
      .den_i (supply_q),
      .quo_o (cq_c[g])
    );
  end

  logic [6:0] flg_dly;

  pvp_delay #(.WIDTH(7), .DEPTH(CDIV_QW)) u_dly_flg (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({lim74_q, neg74_q, ovf74_q}),
    .q_o   (flg_dly)
  );

  // ---------------- output register: clamp to 0..period (period/2 if supply is 0)
  logic [15:0] cmp_c [3];
  logic [15:0] cmp_q [3];
  logic        lim_out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (supply_q == 16'd0) begin
        cmp_c[i] = period_q >> 1;
      end else if (flg_dly[3+i]) begin
        cmp_c[i] = 16'd0;
      end else if (flg_dly[i] || (cq_c[i] > {1'b0, period_q})) begin
        cmp_c[i] = period_q;
      end else begin
        cmp_c[i] = cq_c[i][15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cmp_q[i] <= cmp_c[i];
      end
      lim_out_q <= flg_dly[6];
    end
  end

  assign compare_a_o   = cmp_q[0];
  assign compare_b_o   = cmp_q[1];
  assign compare_c_o   = cmp_q[2];
  assign was_limited_o = lim_out_q;

endmodule
